[rtl/core/prtgb_pkg.sv]
`timescale 1ns / 1ps
package prtgb_pkg;

    localparam int POSE_WORDS = 12;
    localparam int POSE_ROT   = 9;
    localparam int DIV_STEPS  = 32;

    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_CELL_SIZE   = 3'd2;
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd4;

    localparam logic REQ_POSE  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    localparam logic SEL_X = 1'b0;
    localparam logic SEL_Y = 1'b1;

    typedef struct packed {
        logic       pose_we;
        logic       load_pt;
        logic       mul_en;
        logic [3:0] mul_idx;
        logic [1:0] mul_col;
        logic       acc_en;
        logic [1:0] acc_row;
        logic       sat_en;
        logic       div_load;
        logic       div_sel;
        logic       div_step;
        logic       idx_en;
    } t_cmd;

    function automatic logic [1:0] k_row(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] k_col(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/prtgb_ctrl.sv]
`timescale 1ns / 1ps
module prtgb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  logic           i_out_stall,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output prtgb_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SAT  = 3'd2;
    localparam logic [2:0] S_LDX  = 3'd3;
    localparam logic [2:0] S_DIVX = 3'd4;
    localparam logic [2:0] S_LDY  = 3'd5;
    localparam logic [2:0] S_DIVY = 3'd6;
    localparam logic [2:0] S_IDX  = 3'd7;

    localparam logic [4:0] LAST_STEP = 5'(prtgb_pkg::DIV_STEPS - 1);
    localparam logic [4:0] MUL_LAST  = 5'(prtgb_pkg::POSE_ROT);

    logic [2:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic [3:0] k_prev;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign k_prev      = r_cnt[3:0] - 4'd1;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.pose_we = accept && (i_req_type == prtgb_pkg::REQ_POSE);
                o_cmd.load_pt = accept && (i_req_type == prtgb_pkg::REQ_POINT);
                if (o_cmd.load_pt) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                o_cmd.mul_en  = (r_cnt < MUL_LAST);
                o_cmd.mul_idx = r_cnt[3:0];
                o_cmd.mul_col = prtgb_pkg::k_col(r_cnt[3:0]);
                o_cmd.acc_en  = (r_cnt != 5'd0);
                o_cmd.acc_row = prtgb_pkg::k_row(k_prev);
                n_cnt         = r_cnt + 5'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.sat_en = 1'b1;
                n_state      = S_LDX;
            end
            S_LDX: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = prtgb_pkg::SEL_X;
                n_cnt          = '0;
                n_state        = S_DIVX;
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_LDY;
                end
            end
            S_LDY: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = prtgb_pkg::SEL_Y;
                n_cnt          = '0;
                n_state        = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.idx_en = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_point_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == prtgb_pkg::REQ_POINT) |=> (r_state == S_MUL))
        else $error("point did not start multiply");
    a_idx_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDX && !(r_out_valid && i_out_stall)) |=> r_out_valid)
        else $error("result not presented");
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_IDX))
        else $error("result without index step");
`endif

endmodule

[rtl/core/prtgb_dp.sv]
`timescale 1ns / 1ps
module prtgb_dp #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_GRID_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prtgb_pkg::t_cmd     i_cmd,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [3:0]         i_pose_word_index,
    input  logic signed [31:0] i_pose_word_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic [15:0]        i_point_intensity,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic [15:0]        o_out_intensity,
    output logic [23:0]        o_cell_index,
    output logic               o_inside_grid
);

    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic [16:0]        MAXD = 17'(MAX_GRID_DIM);

    logic signed [31:0] r_pose [prtgb_pkg::POSE_WORDS];
    logic signed [31:0] r_pt [3];
    logic [15:0]        r_int;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc [3];
    logic signed [31:0] r_w [3];
    logic signed [31:0] r_origin_x, r_origin_y;
    logic [30:0]        r_cell_size;
    logic [12:0]        r_gw, r_gh;
    logic [31:0]        r_dvd, r_rem;
    logic               r_neg, r_negx;
    logic [31:0]        r_col;

    logic signed [31:0] pt_sel;
    logic signed [63:0] n_prod;
    logic signed [63:0] prod_sh;
    logic signed [32:0] diff;
    logic [30:0]        den;
    logic [31:0]        trial;
    logic               fits;
    logic [12:0]        gw, gh;
    logic               in_grid;
    logic [25:0]        row_off;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] s;
        if (v > 64'sh7FFF_FFFF) begin
            s = 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            s = -32'sh8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    always_comb begin
        case (i_cmd.mul_col)
            2'd0:    pt_sel = r_pt[0];
            2'd1:    pt_sel = r_pt[1];
            default: pt_sel = r_pt[2];
        endcase
        n_prod  = r_pose[i_cmd.mul_idx] * pt_sel;
        prod_sh = r_prod >>> FRAC_BITS;
        diff    = (i_cmd.div_sel == prtgb_pkg::SEL_X)
                ? ({r_w[0][31], r_w[0]} - {r_origin_x[31], r_origin_x})
                : ({r_w[1][31], r_w[1]} - {r_origin_y[31], r_origin_y});
        den     = (r_cell_size == '0) ? 31'd1 : r_cell_size;
        trial   = {r_rem[30:0], r_dvd[31]};
        fits    = (trial >= {1'b0, den});
        gw      = ({4'd0, r_gw} > MAXD) ? MAXD[12:0] : r_gw;
        gh      = ({4'd0, r_gh} > MAXD) ? MAXD[12:0] : r_gh;
        in_grid = !r_negx && !r_neg && (r_col < {19'd0, gw}) && (r_dvd < {19'd0, gh});
        row_off = r_dvd[12:0] * gw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < prtgb_pkg::POSE_WORDS; i++) begin
                r_pose[i] <= (i < prtgb_pkg::POSE_ROT && i % 4 == 0) ? ONE : '0;
            end
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_cell_size <= 31'h0001_0000;
            r_gw        <= 13'd1;
            r_gh        <= 13'd1;
        end else begin
            if (i_cmd.pose_we && i_pose_word_index < 4'(prtgb_pkg::POSE_WORDS)) begin
                r_pose[i_pose_word_index] <= i_pose_word_value;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    prtgb_pkg::CFG_ORIGIN_X:    r_origin_x  <= i_cfg_data;
                    prtgb_pkg::CFG_ORIGIN_Y:    r_origin_y  <= i_cfg_data;
                    prtgb_pkg::CFG_CELL_SIZE:   r_cell_size <= i_cfg_data[30:0];
                    prtgb_pkg::CFG_GRID_WIDTH:  r_gw        <= i_cfg_data[12:0];
                    prtgb_pkg::CFG_GRID_HEIGHT: r_gh        <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_pt[0] <= i_point_x;
            r_pt[1] <= i_point_y;
            r_pt[2] <= i_point_z;
            r_int   <= i_point_intensity;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= 64'(r_pose[prtgb_pkg::POSE_ROT + i]);
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.acc_en) begin
            r_acc[i_cmd.acc_row] <= r_acc[i_cmd.acc_row] + prod_sh;
        end
        if (i_cmd.sat_en) begin
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= sat32(r_acc[i]);
            end
        end
        if (i_cmd.div_load) begin
            r_dvd <= diff[31:0];
            r_neg <= diff[32];
            r_rem <= '0;
            if (i_cmd.div_sel == prtgb_pkg::SEL_Y) begin
                r_col  <= r_dvd;
                r_negx <= r_neg;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= fits ? (trial - {1'b0, den}) : trial;
            r_dvd <= {r_dvd[30:0], fits};
        end
        if (i_cmd.idx_en) begin
            o_world_x       <= r_w[0];
            o_world_y       <= r_w[1];
            o_world_z       <= r_w[2];
            o_out_intensity <= r_int;
            o_inside_grid   <= in_grid;
            o_cell_index    <= in_grid ? 24'({13'd0, r_col[12:0]} + row_off) : 24'd0;
        end
    end

endmodule

[rtl/core/point_rigid_transform_grid_binner.sv]
`timescale 1ns / 1ps
// Each point runs multiply-accumulate steps, one per rotation word, on one shared
// 32x32 multiplier, then two 32-step restoring divisions; the input is stalled until
// its result is issued, and a pose write is taken while idle without leaving idle.
// The next item is accepted while a finished result still waits to be taken.
// Reset (synchronous, active low) restores identity pose and default grid registers.
module point_rigid_transform_grid_binner #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_GRID_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [3:0]         i_pose_word_index,
    input  logic signed [31:0] i_pose_word_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic [15:0]        i_point_intensity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic [15:0]        o_out_intensity,
    output logic [23:0]        o_cell_index,
    output logic               o_inside_grid
);

    prtgb_pkg::t_cmd cmd;

    prtgb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    prtgb_dp #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_GRID_DIM (MAX_GRID_DIM)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pose_word_index (i_pose_word_index),
        .i_pose_word_value (i_pose_word_value),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .i_point_z         (i_point_z),
        .i_point_intensity (i_point_intensity),
        .o_world_x         (o_world_x),
        .o_world_y         (o_world_y),
        .o_world_z         (o_world_z),
        .o_out_intensity   (o_out_intensity),
        .o_cell_index      (o_cell_index),
        .o_inside_grid     (o_inside_grid)
    );

endmodule
